// ===== src/tcp_syn_mss_option_extract_defines.svh =====
// Assertion macros shared by the MSS extractor RTL.
`ifndef TCP_SYN_MSS_OPTION_EXTRACT_DEFINES_SVH
`define TCP_SYN_MSS_OPTION_EXTRACT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSMX_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tsmx_pkg.sv =====
package tsmx_pkg;

  typedef enum logic [7:0] {
    CFG_FLOW_DIRECTION = 8'd0,
    CFG_MSS_OFFSET     = 8'd1,
    CFG_DEFAULT_MSS    = 8'd2,
    CFG_ANNO_SLOT      = 8'd3
  } cfg_idx_e;

  localparam logic [7:0]  OPT_EOL         = 8'd0;
  localparam logic [7:0]  OPT_NOP         = 8'd1;
  localparam logic [7:0]  OPT_MSS         = 8'd2;
  localparam logic [7:0]  OPT_MIN_LEN     = 8'd2;
  localparam logic [7:0]  OPT_MSS_LEN     = 8'd4;
  localparam logic [15:0] DEFAULT_MSS_RST = 16'd536;
  localparam logic [15:0] MSS_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [7:0] flow_id;
    logic       is_syn;
    logic [7:0] opt_byte;
    logic       byte_valid;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  flow_out;
    logic [15:0] mss_value;
    logic [5:0]  anno_where;
    logic        from_syn;
    logic        option_found;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic        mss_seen;
    logic [15:0] mss_gathered;
  } walk_res_t;

endpackage

// ===== src/tsmx_if.sv =====
interface tsmx_in_if;
  logic               valid;
  logic               ready;
  tsmx_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsmx_out_if;
  logic                valid;
  logic                ready;
  tsmx_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsmx_cfg_if;
  logic                valid;
  logic                ready;
  tsmx_pkg::cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tsmx_ram.sv =====
module tsmx_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tsmx_walk.sv =====
module tsmx_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_i,
  input  logic [7:0]          byte_i,
  input  logic                byte_valid_i,
  input  logic                last_i,
  output tsmx_pkg::walk_res_t res_o
);
  import tsmx_pkg::*;

  typedef enum logic [1:0] {
    PH_KIND,
    PH_LEN,
    PH_SKIP,
    PH_GATHER
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  skip_q, skip_d;
  logic [15:0] gath_q, gath_d;
  logic        cnt_q, cnt_d;
  logic        seen_q, seen_d;
  logic        done_q, done_d;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    skip_d  = skip_q;
    gath_d  = gath_q;
    cnt_d   = cnt_q;
    seen_d  = seen_q;
    done_d  = done_q;
    if (byte_valid_i && !done_q) begin
      unique case (phase_q)
        PH_KIND: begin
          if (byte_i == OPT_EOL) begin
            done_d = 1'b1;
          end else if (byte_i != OPT_NOP) begin
            kind_d  = byte_i;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          if (byte_i < OPT_MIN_LEN) begin
            done_d = 1'b1;
          end else if (kind_q == OPT_MSS && byte_i == OPT_MSS_LEN) begin
            gath_d  = '0;
            cnt_d   = 1'b0;
            phase_d = PH_GATHER;
          end else if (byte_i == OPT_MIN_LEN) begin
            phase_d = PH_KIND;
          end else begin
            skip_d  = byte_i - OPT_MIN_LEN;
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - 8'd1;
          if (skip_q == 8'd1) begin
            phase_d = PH_KIND;
          end
        end
        PH_GATHER: begin
          gath_d = {gath_q[7:0], byte_i};
          cnt_d  = 1'b1;
          if (cnt_q) begin
            seen_d = 1'b1;
            done_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KIND;
      kind_q  <= '0;
      skip_q  <= '0;
      gath_q  <= '0;
      cnt_q   <= 1'b0;
      seen_q  <= 1'b0;
      done_q  <= 1'b0;
    end else if (beat_i) begin
      if (last_i) begin
        phase_q <= PH_KIND;
        kind_q  <= '0;
        skip_q  <= '0;
        gath_q  <= '0;
        cnt_q   <= 1'b0;
        seen_q  <= 1'b0;
        done_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        skip_q  <= skip_d;
        gath_q  <= gath_d;
        cnt_q   <= cnt_d;
        seen_q  <= seen_d;
        done_q  <= done_d;
      end
    end
  end

  assign res_o = '{mss_seen: seen_d, mss_gathered: gath_d};

endmodule

// ===== src/tcp_syn_mss_option_extract.sv =====
// Pipeline: once a packet's last option beat is accepted, its result is registered in
// stage 1, then in the output register. Throughput: one option beat per cycle, with
// back-to-back packets, while the output is not stalled; the MSS table is one RAM with
// a registered read and one write port. Reset: registers go to their defaults, then a
// clearing pass zeroes all 2*FLOWS entries, one per cycle, taking no input beat meanwhile.
`include "tcp_syn_mss_option_extract_defines.svh"

module tcp_syn_mss_option_extract #(
  parameter int unsigned FLOWS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsmx_in_if.sink    in_i,
  tsmx_out_if.source out_o,
  tsmx_cfg_if.sink   cfg_i
);
  import tsmx_pkg::*;

  localparam int unsigned DEPTH = 2 * FLOWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned FW    = (FLOWS > 1) ? $clog2(FLOWS) : 1;

  // config
  logic               dir_q;
  logic signed [15:0] offset_q;
  logic [15:0]        dflt_q;
  logic [5:0]         slot_q;

  // clearing pass
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  // pipeline
  logic          s1_v_q, out_v_q;
  logic          s1_syn_q, s1_found_q, fwd_q;
  logic [15:0]   s1_base_q, fwd_val_q;
  logic [AW-1:0] s1_addr_q;
  logic [7:0]    s1_flow_q;
  logic [5:0]    s1_slot_q;
  out_beat_t     out_q;

  logic          in_ready, in_acc, s0_last, s1_adv, s1_fire;
  logic [FW-1:0] flow_mod [256];
  logic [FW-1:0] flow_idx;
  logic [AW-1:0] s0_addr;
  walk_res_t     walk_res;

  logic signed [17:0] sum_s;
  logic [15:0]   syn_val, rd_val, s1_val, ram_rdata;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;

  for (genvar g = 0; g < 256; g++) begin : g_flow_mod
    assign flow_mod[g] = FW'(g % FLOWS);
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= 1'b0;
      offset_q <= '0;
      dflt_q   <= DEFAULT_MSS_RST;
      slot_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_FLOW_DIRECTION: dir_q    <= cfg_i.data.value[0];
        CFG_MSS_OFFSET:     offset_q <= $signed(cfg_i.data.value);
        CFG_DEFAULT_MSS:    dflt_q   <= cfg_i.data.value;
        CFG_ANNO_SLOT:      slot_q   <= cfg_i.data.value[5:0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = !out_v_q || out_o.ready;
  assign s1_fire  = s1_v_q && s1_adv;
  assign in_ready = !clr_busy_q && (!s1_v_q || s1_adv);
  assign in_acc   = in_i.valid && in_ready;
  assign s0_last  = in_acc && in_i.data.last_byte;
  assign in_i.ready = in_ready;

  assign flow_idx = flow_mod[in_i.data.flow_id];
  assign s0_addr  = dir_q ? (AW'(FLOWS) + AW'(flow_idx)) : AW'(flow_idx);

  tsmx_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (in_acc),
    .byte_i       (in_i.data.opt_byte),
    .byte_valid_i (in_i.data.byte_valid),
    .last_i       (in_i.data.last_byte),
    .res_o        (walk_res)
  );

  // offset with negative guard and saturation
  assign sum_s = $signed({2'b00, s1_base_q}) + 18'(offset_q);
  always_comb begin
    if (sum_s[17]) begin
      syn_val = s1_base_q;
    end else if (sum_s[16]) begin
      syn_val = MSS_MAX;
    end else begin
      syn_val = sum_s[15:0];
    end
  end

  assign rd_val = fwd_q ? fwd_val_q : ram_rdata;
  assign s1_val = s1_syn_q ? syn_val : rd_val;

  assign ram_we    = clr_busy_q || (s1_fire && s1_syn_q);
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_busy_q ? '0 : syn_val;
  assign ram_re    = s0_last && !in_i.data.is_syn;

  tsmx_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (s0_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (s0_last) begin
        s1_v_q <= 1'b1;
        fwd_q  <= s1_fire && s1_syn_q && (s1_addr_q == s0_addr);
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
        fwd_q  <= 1'b0;
      end
      if (s1_fire) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_last) begin
      s1_syn_q   <= in_i.data.is_syn;
      s1_found_q <= walk_res.mss_seen;
      s1_base_q  <= walk_res.mss_seen ? walk_res.mss_gathered : dflt_q;
      s1_addr_q  <= s0_addr;
      s1_flow_q  <= in_i.data.flow_id;
      s1_slot_q  <= slot_q;
      fwd_val_q  <= syn_val;
    end
    if (s1_fire) begin
      out_q.flow_out     <= s1_flow_q;
      out_q.mss_value    <= s1_val;
      out_q.anno_where   <= s1_slot_q;
      out_q.from_syn     <= s1_syn_q;
      out_q.option_found <= s1_syn_q && s1_found_q;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  `TSMX_ASSERT_NEXT(a_s1_holds, s1_v_q && out_v_q && !out_o.ready, s1_v_q, "s1 beat lost while output stalled")
  `TSMX_ASSERT_IMPLY(a_found_syn, out_v_q && out_q.option_found, out_q.from_syn, "option_found without SYN")
  `TSMX_ASSERT_IMPLY(a_clr_idle, clr_busy_q, !out_v_q && !s1_v_q, "pipeline active during clearing pass")
  `TSMX_ASSERT_IMPLY(a_fwd_valid, fwd_q, s1_v_q && !clr_busy_q, "forward flag without stage-1 beat")

endmodule

// ===== dv/tcp_syn_mss_option_extract_checker.sv =====
module tcp_syn_mss_option_extract_checker #(
  parameter int FLOWS = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  tsmx_in_if   in_i,
  tsmx_out_if  out_i,
  tsmx_cfg_if  cfg_i,
  output int   errors_o,
  output int   pending_o
);
  import tsmx_pkg::*;

  typedef enum logic [1:0] {WALK_KIND, WALK_LEN, WALK_SKIP, WALK_MSS} walk_phase_e;

  logic [15:0]        mss_tbl [2*FLOWS];
  logic               dir_q;
  logic signed [15:0] offset_q;
  logic [15:0]        dflt_q;
  logic [5:0]         slot_q;

  walk_phase_e walk_ph;
  logic [7:0]  opt_kind;
  logic [7:0]  skip_left;
  logic [15:0] mss_acc;
  logic [1:0]  mss_nbytes;
  logic        mss_ok;
  logic        walk_stop;

  out_beat_t mss_expect_q[$];
  int        err_cnt = 0;

  task automatic walk_restart();
    walk_ph    = WALK_KIND;
    opt_kind   = '0;
    skip_left  = '0;
    mss_acc    = '0;
    mss_nbytes = '0;
    mss_ok     = 1'b0;
    walk_stop  = 1'b0;
  endtask

  task automatic walk_byte(input logic [7:0] b);
    if (walk_stop) return;
    case (walk_ph)
      WALK_KIND: begin
        if (b == OPT_EOL) begin
          walk_stop = 1'b1;
        end else if (b != OPT_NOP) begin
          opt_kind = b;
          walk_ph  = WALK_LEN;
        end
      end
      WALK_LEN: begin
        if (b < OPT_MIN_LEN) begin
          walk_stop = 1'b1;
        end else if (opt_kind == OPT_MSS && b == OPT_MSS_LEN) begin
          mss_acc    = '0;
          mss_nbytes = '0;
          walk_ph    = WALK_MSS;
        end else if (b == OPT_MIN_LEN) begin
          walk_ph = WALK_KIND;
        end else begin
          skip_left = b - OPT_MIN_LEN;
          walk_ph   = WALK_SKIP;
        end
      end
      WALK_SKIP: begin
        skip_left = skip_left - 8'd1;
        if (skip_left == 8'd0) walk_ph = WALK_KIND;
      end
      default: begin
        mss_acc    = {mss_acc[7:0], b};
        mss_nbytes = mss_nbytes + 2'd1;
        if (mss_nbytes >= 2'd2) begin
          mss_ok    = 1'b1;
          walk_stop = 1'b1;
        end
      end
    endcase
  endtask

  // offset is dropped when it would go negative, sum clips at 16 bits
  function automatic logic [15:0] offset_mss(input logic [15:0] base,
                                             input logic signed [15:0] off);
    int sum;
    sum = int'(base) + int'(off);
    if (sum < 0) return base;
    if (sum > 65535) return MSS_MAX;
    return sum[15:0];
  endfunction

  task automatic predict_beat(input in_beat_t b);
    out_beat_t r;
    int        idx;
    if (b.byte_valid) walk_byte(b.opt_byte);
    if (b.last_byte) begin
      idx          = int'(dir_q) * FLOWS + int'(b.flow_id) % FLOWS;
      r.flow_out   = b.flow_id;
      r.anno_where = slot_q;
      r.from_syn   = b.is_syn;
      if (b.is_syn) begin
        r.option_found = mss_ok;
        r.mss_value    = offset_mss(mss_ok ? mss_acc : dflt_q, offset_q);
        mss_tbl[idx]   = r.mss_value;
      end else begin
        r.option_found = 1'b0;
        r.mss_value    = mss_tbl[idx];
      end
      mss_expect_q.push_back(r);
      walk_restart();
    end
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t got;
    out_beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 2*FLOWS; i++) mss_tbl[i] = '0;
      dir_q    = 1'b0;
      offset_q = '0;
      dflt_q   = DEFAULT_MSS_RST;
      slot_q   = '0;
      walk_restart();
      mss_expect_q.delete();
      pending_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got = out_i.data;
        if (mss_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat, expected none, actual flow %0d mss %0d",
                   $time, got.flow_out, got.mss_value);
        end else begin
          want = mss_expect_q.pop_front();
          check_field("flow_out", 16'(want.flow_out), 16'(got.flow_out));
          check_field("mss_value", want.mss_value, got.mss_value);
          check_field("anno_where", 16'(want.anno_where), 16'(got.anno_where));
          check_field("from_syn", 16'(want.from_syn), 16'(got.from_syn));
          check_field("option_found", 16'(want.option_found), 16'(got.option_found));
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.data.index)
          CFG_FLOW_DIRECTION: dir_q    = cfg_i.data.value[0];
          CFG_MSS_OFFSET:     offset_q = cfg_i.data.value;
          CFG_DEFAULT_MSS:    dflt_q   = cfg_i.data.value;
          CFG_ANNO_SLOT:      slot_q   = cfg_i.data.value[5:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) predict_beat(in_i.data);
      pending_o <= mss_expect_q.size();
    end
    errors_o <= err_cnt;
  end

endmodule

// ===== dv/tcp_syn_mss_option_extract_tb.sv =====
module tcp_syn_mss_option_extract_tb;
  import tsmx_pkg::*;

  typedef logic [7:0] opt_bytes_t[$];

  localparam int         FLOWS        = 256;
  localparam int         ITEM_TARGET  = 1600;
  localparam int         HOLD_CYCLES  = 600;
  localparam int         CYCLE_LIMIT  = 300000;
  localparam logic [7:0] CFG_IDX_NONE = 8'hFF;

  logic clk_i;
  logic rst_ni;

  tsmx_in_if  in_bus();
  tsmx_out_if out_bus();
  tsmx_cfg_if cfg_bus();

  int          errors;
  int          pending;
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  int          beats_sent = 0;
  int          packets_sent = 0;
  int          settings_used = 0;
  int unsigned cycles = 0;
  logic [7:0]  flow_pool [8];

  tcp_syn_mss_option_extract #(.FLOWS(FLOWS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  tcp_syn_mss_option_extract_checker #(.FLOWS(FLOWS)) mss_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_bus),
    .out_i     (out_bus),
    .cfg_i     (cfg_bus),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_drain
    int gap;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
    end
  end

  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= b;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  // flow and SYN of the closing beat count; earlier beats carry noise there
  task automatic send_packet(input opt_bytes_t opts, input logic [7:0] flow,
                             input logic syn, input int empty_pct);
    in_beat_t b;
    bit       empty_last;
    empty_last = (opts.size() == 0) || ($urandom_range(1, 100) <= empty_pct);
    for (int i = 0; i < opts.size(); i++) begin
      if ($urandom_range(1, 100) <= empty_pct) begin
        b.flow_id    = 8'($urandom);
        b.is_syn     = 1'($urandom);
        b.opt_byte   = 8'($urandom);
        b.byte_valid = 1'b0;
        b.last_byte  = 1'b0;
        send_beat(b);
      end
      b.last_byte  = (i == opts.size() - 1) && !empty_last;
      b.flow_id    = b.last_byte ? flow : 8'($urandom);
      b.is_syn     = b.last_byte ? syn : 1'($urandom);
      b.opt_byte   = opts[i];
      b.byte_valid = 1'b1;
      send_beat(b);
    end
    if (empty_last) begin
      b.flow_id    = flow;
      b.is_syn     = syn;
      b.opt_byte   = 8'($urandom);
      b.byte_valid = 1'b0;
      b.last_byte  = 1'b1;
      send_beat(b);
    end
    packets_sent++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_beat_t w;
    w.index = idx;
    w.value = val;
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= w;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic dir, input logic [15:0] off,
                          input logic [15:0] dflt, input logic [5:0] slot);
    write_reg(CFG_FLOW_DIRECTION, {15'($urandom), dir});
    write_reg(CFG_MSS_OFFSET, off);
    write_reg(CFG_DEFAULT_MSS, dflt);
    write_reg(CFG_ANNO_SLOT, {10'($urandom), slot});
    write_reg($urandom_range(0, 1) ? CFG_IDX_NONE : 8'($urandom_range(4, 254)),
              16'($urandom));
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_flow();
    if ($urandom_range(0, 4) != 0) return flow_pool[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  task automatic make_options(output opt_bytes_t q);
    int style;
    int len;
    q.delete();
    style = $urandom_range(0, 99);
    if (style < 75) begin
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 7))
          0: q.push_back(OPT_NOP);
          1: begin
            q.push_back(OPT_MSS);
            q.push_back(OPT_MSS_LEN);
            q.push_back(8'($urandom));
            q.push_back(8'($urandom));
          end
          2: begin
            q.push_back(8'd3);
            q.push_back(8'd3);
            q.push_back(8'($urandom));
          end
          3: begin
            q.push_back(8'd4);
            q.push_back(8'd2);
          end
          4: begin
            q.push_back(8'd8);
            q.push_back(8'd10);
            repeat (8) q.push_back(8'($urandom));
          end
          5: begin
            len = $urandom_range(2, 6);
            q.push_back(8'($urandom_range(3, 255)));
            q.push_back(8'(len));
            repeat (len - 2) q.push_back(8'($urandom));
          end
          6: begin
            q.push_back(OPT_EOL);
            repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
          end
          default: begin
            // MSS kind with a length other than 4
            len = $urandom_range(2, 5);
            if (len >= 4) len++;
            q.push_back(OPT_MSS);
            q.push_back(8'(len));
            repeat (len - 2) q.push_back(8'($urandom));
          end
        endcase
      end
    end else if (style < 90) begin
      if ($urandom_range(0, 1)) q.push_back(OPT_NOP);
      case ($urandom_range(0, 3))
        0: begin
          q.push_back(OPT_MSS);
          q.push_back(OPT_MSS_LEN);
          repeat ($urandom_range(0, 1)) q.push_back(8'($urandom));
        end
        1: q.push_back(8'($urandom_range(2, 255)));
        2: begin
          q.push_back(8'($urandom_range(3, 255)));
          q.push_back(8'($urandom_range(3, 255)));
          repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
        end
        default: begin
          q.push_back(8'($urandom_range(2, 255)));
          q.push_back(8'($urandom_range(0, 1)));
          q.push_back(OPT_MSS);
          q.push_back(OPT_MSS_LEN);
          q.push_back(8'($urandom));
          q.push_back(8'($urandom));
        end
      endcase
    end else begin
      repeat ($urandom_range(0, 12)) q.push_back(8'($urandom));
    end
  endtask

  initial begin : stimulus
    opt_bytes_t opts;
    int         phase;
    int         npkt;
    rst_ni        <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.data   <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data  <= '0;
    flow_pool[0] = 8'd0;
    flow_pool[1] = 8'd255;
    for (int i = 2; i < 8; i++) flow_pool[i] = 8'($urandom);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    opts.delete();
    send_packet(opts, 8'd0, 1'b1, 0);
    opts = {OPT_MSS, OPT_MSS_LEN, 8'hFF, 8'hFF};
    send_packet(opts, 8'd255, 1'b1, 0);
    opts.delete();
    send_packet(opts, 8'd9, 1'b0, 0);
    opts = {OPT_NOP, OPT_EOL, OPT_MSS, OPT_MSS_LEN, 8'h05, 8'hB4};
    send_packet(opts, 8'd1, 1'b1, 0);
    opts = {8'd3, 8'd1, OPT_MSS, OPT_MSS_LEN, 8'h12, 8'h34};
    send_packet(opts, 8'd2, 1'b1, 0);
    opts = {8'd8, 8'd2, OPT_MSS, OPT_MSS_LEN, 8'h05};
    send_packet(opts, 8'd3, 1'b1, 0);
    opts = {OPT_MSS, 8'd5, 8'h00, 8'h00, 8'h00};
    send_packet(opts, 8'd6, 1'b1, 0);
    opts = {OPT_MSS, OPT_MSS_LEN, 8'h00, 8'h00};
    send_packet(opts, 8'd4, 1'b1, 100);
    opts.delete();
    send_packet(opts, 8'd255, 1'b0, 0);
    settle();

    // negative offset extremes on the other bank
    set_regs(1'b1, 16'h8000, 16'h0000, 6'd63);
    opts.delete();
    send_packet(opts, 8'd0, 1'b1, 0);
    opts = {OPT_MSS, OPT_MSS_LEN, 8'h80, 8'h01};
    send_packet(opts, 8'd1, 1'b1, 0);
    opts.delete();
    send_packet(opts, 8'd1, 1'b0, 0);
    settle();

    // saturation
    set_regs(1'b0, 16'h7FFF, 16'hFFFF, 6'd46);
    opts.delete();
    send_packet(opts, 8'd5, 1'b1, 0);
    send_packet(opts, 8'd255, 1'b0, 0);
    send_packet(opts, 8'd0, 1'b0, 0);
    settle();

    phase = 0;
    while (beats_sent < ITEM_TARGET) begin
      case (phase % 6)
        0: set_regs(1'b0, 16'h0000, DEFAULT_MSS_RST, 6'd0);
        1: set_regs(1'b1, 16'hFFEC, 16'd1460, 6'd46);
        2: set_regs(1'b0, 16'h8000, 16'hFFFF, 6'd63);
        3: set_regs(1'b1, 16'h7FFF, 16'd0, 6'd17);
        4: set_regs(1'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
        default: set_regs(1'b0, 16'h0028, 16'd1220, 6'd32);
      endcase
      idle_on = (phase % 3) != 1;
      npkt = 30;
      if (phase == 2) begin
        hold_req = 1'b1;
        npkt     = 60;
      end
      repeat (npkt) begin
        make_options(opts);
        send_packet(opts, pick_flow(), 1'($urandom), $urandom_range(0, 15));
      end
      settle();
      phase++;
    end

    settle();
    $display("Sent %0d input beats in %0d packets under %0d register settings,",
             beats_sent, packets_sent, settings_used);
    $display("with random idles on both channels and one long result hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
